/* rtl/imms_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imms_pkg
// Shared types and constants for the interval min/max/mean statistics core.
// ---------------------------------------------------------------------------
package imms_pkg;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SREAD,
        S_SWRITE,
        S_RREAD,
        S_RCALC,
        S_RDIV,
        S_ROUT
    } state_t;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_ENERGY_SCALE    = 2'd0;
    localparam logic [1:0] REG_ACTIVE_CHANNEL  = 2'd1;
    localparam logic [1:0] REG_REACTIVE_CHANNEL = 2'd2;
    localparam logic [1:0] REG_CHANNELS_IN_USE = 2'd3;

    // Reset values of the registers.
    localparam logic [15:0] ENERGY_SCALE_RST = 16'd256;
    localparam logic [3:0]  ACTIVE_CH_RST    = 4'd3;
    localparam logic [3:0]  REACTIVE_CH_RST  = 4'd4;
    localparam logic [4:0]  CH_IN_USE_RST    = 5'd16;

    // Minimum seed: 65535.0 in Q23.8, needs 25 signed bits.
    localparam int MIN_SEED_VAL = 16776960;
    localparam int MIN_SEED_W   = 25;

    // Fixed field widths.
    localparam int CH_FIELD_W = 4;
    localparam int ENERGY_W   = 64;

endpackage

/* rtl/imms_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imms_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module imms_div #(
    parameter int DW = 48,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dvd_reg, dvd_next;
    logic [VW:0]   rem_reg, rem_next;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial     = {rem_reg[VW-1:0], dvd_reg[DW-1]};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* rtl/interval_min_max_mean_stats_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_min_max_mean_stats_core
// Per-channel sum, minimum, maximum and count with energy totals; a report
// item emits mean, minimum, maximum and count per channel and clears.
// ---------------------------------------------------------------------------
//  Channel   Dir  Carries
//  s_axis    in   tuser: kind; tdata: channel[3:0], value
//  m_axis    out  tuser: empty_res; tlast: last; tdata: out_channel, mean,
//                 minimum, maximum, sample_count, active and reactive energy
//  APB       in   energy_scale, active/reactive power channel, channels_in_use
//
//  A sample passes through accept, a read of the channel memory and write
//  back; the input stays closed until the sequencer is idle again. A report
//  forms each nonempty channel's mean with the bit-serial divider.
//  Reset and each report clear the channel memory at once through per-entry
//  valid bits. The result register frees the sequencer: a stalled output only
//  holds the report at its next result.
// ---------------------------------------------------------------------------
module interval_min_max_mean_stats_core #(
    parameter int NUM_CHANNELS = 16,
    parameter int VALUE_WIDTH  = 32,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic clk,
    input  logic rst_n,
    // Input stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: channel [3:0], value [4 +: VALUE_WIDTH], zero pad
    input  logic [((imms_pkg::CH_FIELD_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: kind
    input  logic s_axis_tuser,
    // Output stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: out_channel, mean, minimum, maximum, sample_count,
    //        active_energy, reactive_energy, zero pad
    output logic [((imms_pkg::CH_FIELD_W + 3 * VALUE_WIDTH + COUNT_WIDTH
                   + 2 * imms_pkg::ENERGY_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tuser: empty_res
    output logic m_axis_tuser,
    output logic m_axis_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int V      = VALUE_WIDTH;
    localparam int C      = COUNT_WIDTH;
    localparam int CHW    = imms_pkg::CH_FIELD_W;
    localparam int EW     = imms_pkg::ENERGY_W;
    localparam int SUM_W  = V + C;
    localparam int MIN_W  = (V > imms_pkg::MIN_SEED_W) ? V : imms_pkg::MIN_SEED_W;
    localparam int ENT_W  = SUM_W + MIN_W + V + C;
    localparam int AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PROD_W = V + 17;
    localparam int OUT_F  = CHW + 3 * V + C + 2 * EW;
    localparam int OUT_W  = ((OUT_F + 7) / 8) * 8;
    localparam logic signed [MIN_W-1:0] MIN_SEED = MIN_W'(imms_pkg::MIN_SEED_VAL);
    localparam logic signed [EW:0] E_MAX = {2'b00, {(EW-1){1'b1}}};
    localparam logic signed [EW:0] E_MIN = {2'b11, {(EW-1){1'b0}}};

    // -----------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------
    logic [15:0] energy_scale_reg;
    logic [3:0]  active_ch_reg;
    logic [3:0]  reactive_ch_reg;
    logic [4:0]  ch_in_use_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_scale_reg <= imms_pkg::ENERGY_SCALE_RST;
            active_ch_reg    <= imms_pkg::ACTIVE_CH_RST;
            reactive_ch_reg  <= imms_pkg::REACTIVE_CH_RST;
            ch_in_use_reg    <= imms_pkg::CH_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                imms_pkg::REG_ENERGY_SCALE:     energy_scale_reg <= pwdata[15:0];
                imms_pkg::REG_ACTIVE_CHANNEL:   active_ch_reg    <= pwdata[3:0];
                imms_pkg::REG_REACTIVE_CHANNEL: reactive_ch_reg  <= pwdata[3:0];
                imms_pkg::REG_CHANNELS_IN_USE:  ch_in_use_reg    <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[3:2])
            imms_pkg::REG_ENERGY_SCALE:     prdata = {16'd0, energy_scale_reg};
            imms_pkg::REG_ACTIVE_CHANNEL:   prdata = {28'd0, active_ch_reg};
            imms_pkg::REG_REACTIVE_CHANNEL: prdata = {28'd0, reactive_ch_reg};
            imms_pkg::REG_CHANNELS_IN_USE:  prdata = {27'd0, ch_in_use_reg};
            default:                        prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------
    // Channel memory with per-entry valid bits
    // -----------------------------------------------------------------
    logic [ENT_W-1:0]        mem [NUM_CHANNELS];
    logic [ENT_W-1:0]        mem_q_reg;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                    mem_we;
    logic [ENT_W-1:0]        mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        mem_q_reg <= mem[addr_reg];
    end

    // Entry fields; an entry that is not valid reads as its seeds.
    logic signed [SUM_W-1:0] e_sum;
    logic signed [MIN_W-1:0] e_min;
    logic signed [V-1:0]     e_max;
    logic [C-1:0]            e_cnt;
    logic [SUM_W-1:0]        e_abs;

    always_comb
    begin
        if (valid_reg[addr_reg])
        begin
            {e_sum, e_min, e_max, e_cnt} = mem_q_reg;
        end
        else
        begin
            e_sum = '0;
            e_min = MIN_SEED;
            e_max = '0;
            e_cnt = '0;
        end
    end

    // Magnitude of the sum, handed to the divider as it starts.
    assign e_abs = e_sum[SUM_W-1] ? SUM_W'(-e_sum) : SUM_W'(e_sum);

    // -----------------------------------------------------------------
    // Sequencer and datapath registers
    // -----------------------------------------------------------------
    imms_pkg::state_t state_reg, state_next;

    logic [CHW-1:0]           ch_reg;
    logic signed [V-1:0]      value_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [EW-1:0]     act_e_reg, act_e_next;
    logic signed [EW-1:0]     react_e_reg, react_e_next;
    logic [AW-1:0]            last_ch_reg;
    logic                     neg_reg;
    logic [C-1:0]             cur_cnt_reg;
    logic signed [V-1:0]      cur_min_reg, cur_max_reg;
    logic                     div_start;
    logic                     div_done;
    logic [SUM_W-1:0]         div_q;
    logic [SUM_W-1:0]         q_reg;
    logic                     q_load;
    logic                     load_cur;
    logic                     clear_all;
    logic                     sample_commit;
    logic                     out_load;
    logic                     in_range;
    logic                     accept;
    logic [5:0]               n_ch;

    // Output register
    logic                 out_valid_reg;
    logic [CHW-1:0]       o_ch_reg;
    logic [V-1:0]         o_mean_reg, o_min_reg, o_max_reg;
    logic [C-1:0]         o_cnt_reg;
    logic                 o_empty_reg, o_last_reg;
    logic [EW-1:0]        o_act_reg, o_react_reg;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign in_range = 32'(ch_reg) < NUM_CHANNELS;

    // Clamped count of channels to report.
    always_comb
    begin
        if (ch_in_use_reg == 5'd0)
        begin
            n_ch = 6'd1;
        end
        else if (32'(ch_in_use_reg) > NUM_CHANNELS)
        begin
            n_ch = 6'(NUM_CHANNELS);
        end
        else
        begin
            n_ch = {1'b0, ch_in_use_reg};
        end
    end

    // Updated entry and energy totals for a sample.
    logic signed [SUM_W-1:0] new_sum;
    logic signed [MIN_W-1:0] v_ext;
    logic signed [EW:0]      prod_ext;
    logic signed [EW:0]      act_sum, react_sum;

    assign new_sum  = e_sum + SUM_W'(value_reg);
    assign v_ext    = MIN_W'(value_reg);
    assign prod_ext = (EW + 1)'(prod_reg);
    assign act_sum  = (EW + 1)'(act_e_reg) + prod_ext;
    assign react_sum = (EW + 1)'(react_e_reg) + prod_ext;

    always_comb
    begin
        mem_wdata = {new_sum,
                     (v_ext < e_min) ? v_ext : e_min,
                     (value_reg > e_max) ? value_reg : e_max,
                     e_cnt + 1'b1};
    end

    // Next state and control.
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        s_axis_tready = 1'b0;
        sample_commit = 1'b0;
        mem_we        = 1'b0;
        load_cur      = 1'b0;
        div_start     = 1'b0;
        q_load        = 1'b0;
        out_load      = 1'b0;
        clear_all     = 1'b0;
        case (state_reg)
            imms_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (accept)
                begin
                    if (s_axis_tuser)
                    begin
                        addr_next  = '0;
                        state_next = imms_pkg::S_RREAD;
                    end
                    else
                    begin
                        addr_next  = AW'(s_axis_tdata[CHW-1:0]);
                        state_next = imms_pkg::S_SREAD;
                    end
                end
            end
            imms_pkg::S_SREAD:
            begin
                state_next = imms_pkg::S_SWRITE;
            end
            imms_pkg::S_SWRITE:
            begin
                if (in_range && e_cnt != {C{1'b1}})
                begin
                    sample_commit = 1'b1;
                    mem_we        = 1'b1;
                end
                state_next = imms_pkg::S_IDLE;
            end
            imms_pkg::S_RREAD:
            begin
                state_next = imms_pkg::S_RCALC;
            end
            imms_pkg::S_RCALC:
            begin
                load_cur = 1'b1;
                if (e_cnt == '0)
                begin
                    state_next = imms_pkg::S_ROUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = imms_pkg::S_RDIV;
                end
            end
            imms_pkg::S_RDIV:
            begin
                if (div_done)
                begin
                    q_load     = 1'b1;
                    state_next = imms_pkg::S_ROUT;
                end
            end
            imms_pkg::S_ROUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    if (addr_reg == last_ch_reg)
                    begin
                        clear_all  = 1'b1;
                        state_next = imms_pkg::S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + 1'b1;
                        state_next = imms_pkg::S_RREAD;
                    end
                end
            end
            default:
            begin
                state_next = imms_pkg::S_IDLE;
            end
        endcase
    end

    // Saturating energy accumulation.
    always_comb
    begin
        act_e_next   = act_e_reg;
        react_e_next = react_e_reg;
        if (clear_all)
        begin
            act_e_next   = '0;
            react_e_next = '0;
        end
        else if (sample_commit)
        begin
            if (ch_reg == active_ch_reg)
            begin
                act_e_next = (act_sum > E_MAX) ? EW'(E_MAX) :
                             (act_sum < E_MIN) ? EW'(E_MIN) : EW'(act_sum);
            end
            if (ch_reg == reactive_ch_reg)
            begin
                react_e_next = (react_sum > E_MAX) ? EW'(E_MAX) :
                               (react_sum < E_MIN) ? EW'(E_MIN) : EW'(react_sum);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imms_pkg::S_IDLE;
            addr_reg      <= '0;
            valid_reg     <= '0;
            act_e_reg     <= '0;
            react_e_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            act_e_reg   <= act_e_next;
            react_e_reg <= react_e_next;
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (sample_commit)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg      <= s_axis_tdata[CHW-1:0];
            value_reg   <= s_axis_tdata[CHW +: V];
            last_ch_reg <= AW'(n_ch - 6'd1);
        end
        if (state_reg == imms_pkg::S_SREAD)
        begin
            prod_reg <= value_reg * $signed({1'b0, energy_scale_reg});
        end
        if (load_cur)
        begin
            neg_reg     <= e_sum[SUM_W-1];
            cur_cnt_reg <= e_cnt;
            cur_min_reg <= V'(e_min);
            cur_max_reg <= e_max;
            q_reg       <= '0;
        end
        else if (q_load)
        begin
            q_reg <= neg_reg ? SUM_W'(-div_q) : div_q;
        end
        if (out_load)
        begin
            o_ch_reg    <= CHW'(addr_reg);
            o_mean_reg  <= V'(q_reg);
            o_min_reg   <= cur_min_reg;
            o_max_reg   <= cur_max_reg;
            o_cnt_reg   <= cur_cnt_reg;
            o_empty_reg <= (cur_cnt_reg == '0);
            o_act_reg   <= act_e_reg;
            o_react_reg <= react_e_reg;
            o_last_reg  <= (addr_reg == last_ch_reg);
        end
    end

    // Mean divider, loaded straight from the entry just read.
    imms_div #(
        .DW(SUM_W),
        .VW(C)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (e_abs),
        .divisor  (e_cnt),
        .done     (div_done),
        .quotient (div_q)
    );

    // Output stream.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = o_empty_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = OUT_W'({o_react_reg, o_act_reg, o_cnt_reg, o_max_reg,
                                   o_min_reg, o_mean_reg, o_ch_reg});

endmodule

/* rtl/imms_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imms_checker
// Port-level checks for the interval statistics core.
// ---------------------------------------------------------------------------
module imms_checker #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 16,
    parameter int OUT_W       = 248
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser,
    input logic             m_axis_tlast
);

    localparam int MEAN_LO = imms_pkg::CH_FIELD_W;
    localparam int CNT_LO  = imms_pkg::CH_FIELD_W + 3 * VALUE_WIDTH;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // An empty channel reports a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[CNT_LO +: COUNT_WIDTH] == '0)
        else $error("empty result with nonzero count");

    // An empty channel reports a zero mean.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[MEAN_LO +: VALUE_WIDTH] == '0)
        else $error("empty result with nonzero mean");

    // A sample transfer keeps the input closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
        else $error("input reopened during sample update");

endmodule

bind interval_min_max_mean_stats_core imms_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .OUT_W       ($bits(m_axis_tdata))
) u_imms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
